>>> hw/rtl/vmmio_pkg.sv
// vmmio_pkg: shared types, codes and constants of the virtio-mmio register core
// no dependencies
`timescale 1ns / 1ps

package vmmio_pkg;

   localparam int NUM_QUEUES_DEF     = 2;
   localparam int MAX_QUEUE_SIZE_DEF = 256;

   localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
   localparam logic [31:0] VERSION_VALUE = 32'd2;
   localparam int          VERSION_1_BIT = 32;
   localparam logic [7:0]  ST_FEATURES_OK = 8'h08;

   // item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_RAISE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEVICE_KIND  = 2'd0;
   localparam logic [1:0] CSR_OFFERED      = 2'd1;
   localparam logic [1:0] CSR_SIZE_LIMIT   = 2'd2;

   // register offsets
   localparam logic [7:0] OFF_MAGIC      = 8'h00;
   localparam logic [7:0] OFF_VERSION    = 8'h04;
   localparam logic [7:0] OFF_DEVICE_ID  = 8'h08;
   localparam logic [7:0] OFF_DEV_FEAT   = 8'h10;
   localparam logic [7:0] OFF_DEV_PAGE   = 8'h14;
   localparam logic [7:0] OFF_DRV_FEAT   = 8'h20;
   localparam logic [7:0] OFF_DRV_PAGE   = 8'h24;
   localparam logic [7:0] OFF_QUEUE_SEL  = 8'h30;
   localparam logic [7:0] OFF_QUEUE_MAX  = 8'h34;
   localparam logic [7:0] OFF_QUEUE_NUM  = 8'h38;
   localparam logic [7:0] OFF_QUEUE_RDY  = 8'h44;
   localparam logic [7:0] OFF_NOTIFY     = 8'h50;
   localparam logic [7:0] OFF_INT_STATUS = 8'h60;
   localparam logic [7:0] OFF_INT_ACK    = 8'h64;
   localparam logic [7:0] OFF_STATUS     = 8'h70;
   localparam logic [7:0] OFF_DESC_LO    = 8'h80;
   localparam logic [7:0] OFF_DESC_HI    = 8'h84;
   localparam logic [7:0] OFF_AVAIL_LO   = 8'h90;
   localparam logic [7:0] OFF_AVAIL_HI   = 8'h94;
   localparam logic [7:0] OFF_USED_LO    = 8'hA0;
   localparam logic [7:0] OFF_USED_HI    = 8'hA4;

   // command from controller to datapath
   typedef struct packed {
      logic execute;
      logic capture;
   } cmd_type;

endpackage

>>> hw/rtl/vmmio_ctrl.sv
// vmmio_ctrl: handshake controller, one item in flight
// depends on vmmio_pkg
`timescale 1ns / 1ps

module vmmio_ctrl
   import vmmio_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff, state_in;
   logic take;
   logic give;

   assign rsp_valid = (state_ff == ST_HOLD);
   assign give      = rsp_valid && rsp_ready;
   // a new beat may enter while the held result leaves
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign take      = req_valid && req_ready;

   assign cmd.execute = take;
   assign cmd.capture = take;

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = ST_HOLD;
      end else if (give) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid) else $error("no result after beat");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("idle but not ready");
`endif

endmodule

>>> hw/rtl/vmmio_datapath.sv
// vmmio_datapath: transport registers, decode and result register
// depends on vmmio_pkg
`timescale 1ns / 1ps

module vmmio_datapath
   import vmmio_pkg::*;
#(
   parameter int NUM_QUEUES     = NUM_QUEUES_DEF,
   parameter int MAX_QUEUE_SIZE = MAX_QUEUE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_offset,
   input  logic [31:0] req_write_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output logic [31:0] rsp_read_data,
   output logic        rsp_notify_valid,
   output logic [15:0] rsp_notify_queue,
   output logic        rsp_interrupt_pending
);

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [15:0] MAX_SZ = 16'(MAX_QUEUE_SIZE);

   logic [7:0]  device_kind_ff;
   logic [63:0] offered_ff;
   logic [8:0]  size_limit_ff;

   logic [7:0]  status_ff, status_in;
   logic        offer_page_ff, offer_page_in;
   logic        accept_page_ff, accept_page_in;
   logic [63:0] accepted_ff, accepted_in;
   logic [15:0] sel_ff, sel_in;
   logic [15:0] qlen_ff  [NUM_QUEUES];
   logic [15:0] qlen_in  [NUM_QUEUES];
   logic        qlive_ff [NUM_QUEUES];
   logic        qlive_in [NUM_QUEUES];
   logic [63:0] desc_ff  [NUM_QUEUES];
   logic [63:0] desc_in  [NUM_QUEUES];
   logic [63:0] avail_ff [NUM_QUEUES];
   logic [63:0] avail_in [NUM_QUEUES];
   logic [63:0] used_ff  [NUM_QUEUES];
   logic [63:0] used_in  [NUM_QUEUES];
   logic [1:0]  int_ff, int_in;

   logic [31:0] rd_ff, rd_in;
   logic        nv_ff, nv_in;
   logic [15:0] nq_ff, nq_in;

   logic        q_ok;
   logic [QW-1:0] q;
   logic [15:0] cap;
   logic        aligned;
   logic        wr;
   logic [7:0]  s_new;
   logic        feat_ok;

   always_comb begin
      q_ok = (sel_ff < 16'(NUM_QUEUES));
      q    = q_ok ? sel_ff[QW-1:0] : '0;
      cap  = ({7'd0, size_limit_ff} > MAX_SZ) ? MAX_SZ : {7'd0, size_limit_ff};
      aligned = (req_offset[1:0] == 2'b00);
      wr = cmd.execute && (req_kind == KIND_WRITE) && aligned;
      feat_ok = ((accepted_ff & ~offered_ff) == 64'd0) && accepted_ff[VERSION_1_BIT];
      s_new = req_write_data[7:0];
      if (!feat_ok) begin
         s_new = s_new & ~ST_FEATURES_OK;
      end
   end

   always_comb begin
      status_in      = status_ff;
      offer_page_in  = offer_page_ff;
      accept_page_in = accept_page_ff;
      accepted_in    = accepted_ff;
      sel_in         = sel_ff;
      qlen_in        = qlen_ff;
      qlive_in       = qlive_ff;
      desc_in        = desc_ff;
      avail_in       = avail_ff;
      used_in        = used_ff;
      int_in         = int_ff;
      rd_in          = 32'd0;
      nv_in          = 1'b0;
      nq_in          = 16'd0;
      if (cmd.execute && (req_kind == KIND_READ) && aligned) begin
         unique case (req_offset)
            OFF_MAGIC:      rd_in = MAGIC_VALUE;
            OFF_VERSION:    rd_in = VERSION_VALUE;
            OFF_DEVICE_ID:  rd_in = {24'd0, device_kind_ff};
            OFF_DEV_FEAT:   rd_in = offer_page_ff ? offered_ff[63:32] : offered_ff[31:0];
            OFF_QUEUE_MAX:  rd_in = q_ok ? {16'd0, cap} : 32'd0;
            OFF_QUEUE_RDY:  rd_in = q_ok ? {31'd0, qlive_ff[q]} : 32'd0;
            OFF_INT_STATUS: rd_in = {30'd0, int_ff};
            OFF_STATUS:     rd_in = {24'd0, status_ff};
            default:        rd_in = 32'd0;
         endcase
      end
      if (cmd.execute && (req_kind == KIND_RAISE)) begin
         int_in = int_ff | req_write_data[1:0];
      end
      if (wr) begin
         unique case (req_offset)
            OFF_NOTIFY: begin
               nv_in = 1'b1;
               nq_in = req_write_data[15:0];
            end
            OFF_DEV_PAGE:  offer_page_in = req_write_data[0];
            OFF_DRV_FEAT: begin
               if (accept_page_ff) accepted_in[63:32] = req_write_data;
               else accepted_in[31:0] = req_write_data;
            end
            OFF_DRV_PAGE:  accept_page_in = req_write_data[0];
            OFF_QUEUE_SEL: sel_in = req_write_data[15:0];
            OFF_QUEUE_NUM: begin
               if (q_ok && req_write_data != 32'd0 && req_write_data <= {16'd0, cap})
                  qlen_in[q] = req_write_data[15:0];
            end
            OFF_QUEUE_RDY: if (q_ok) qlive_in[q] = req_write_data[0];
            OFF_INT_ACK:   int_in = int_ff & ~req_write_data[1:0];
            OFF_STATUS: begin
               if (req_write_data == 32'd0) begin
                  // device reset
                  status_in      = 8'd0;
                  offer_page_in  = 1'b0;
                  accept_page_in = 1'b0;
                  accepted_in    = 64'd0;
                  sel_in         = 16'd0;
                  int_in         = 2'd0;
                  for (int i = 0; i < NUM_QUEUES; i++) begin
                     qlen_in[i]  = 16'd0;
                     qlive_in[i] = 1'b0;
                     desc_in[i]  = 64'd0;
                     avail_in[i] = 64'd0;
                     used_in[i]  = 64'd0;
                  end
               end else begin
                  status_in = s_new;
               end
            end
            OFF_DESC_LO:  if (q_ok) desc_in[q][31:0]   = req_write_data;
            OFF_DESC_HI:  if (q_ok) desc_in[q][63:32]  = req_write_data;
            OFF_AVAIL_LO: if (q_ok) avail_in[q][31:0]  = req_write_data;
            OFF_AVAIL_HI: if (q_ok) avail_in[q][63:32] = req_write_data;
            OFF_USED_LO:  if (q_ok) used_in[q][31:0]   = req_write_data;
            OFF_USED_HI:  if (q_ok) used_in[q][63:32]  = req_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_kind_ff <= 8'd0;
         offered_ff     <= 64'h1_0000_0000;
         size_limit_ff  <= 9'd256;
         status_ff      <= 8'd0;
         offer_page_ff  <= 1'b0;
         accept_page_ff <= 1'b0;
         accepted_ff    <= 64'd0;
         sel_ff         <= 16'd0;
         int_ff         <= 2'd0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            qlen_ff[i]  <= 16'd0;
            qlive_ff[i] <= 1'b0;
            desc_ff[i]  <= 64'd0;
            avail_ff[i] <= 64'd0;
            used_ff[i]  <= 64'd0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEVICE_KIND: device_kind_ff <= csr_write_data[7:0];
               CSR_OFFERED:     offered_ff     <= csr_write_data;
               CSR_SIZE_LIMIT:  size_limit_ff  <= csr_write_data[8:0];
               default: ;
            endcase
         end
         status_ff      <= status_in;
         offer_page_ff  <= offer_page_in;
         accept_page_ff <= accept_page_in;
         accepted_ff    <= accepted_in;
         sel_ff         <= sel_in;
         int_ff         <= int_in;
         qlen_ff        <= qlen_in;
         qlive_ff       <= qlive_in;
         desc_ff        <= desc_in;
         avail_ff       <= avail_in;
         used_ff        <= used_in;
      end
   end

   // result register, loaded per accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= rd_in;
         nv_ff <= nv_in;
         nq_ff <= nq_in;
      end
   end

   assign rsp_read_data         = rd_ff;
   assign rsp_notify_valid      = nv_ff;
   assign rsp_notify_queue      = nq_ff;
   assign rsp_interrupt_pending = (int_ff != 2'd0);

`ifndef SYNTHESIS
   a_qlen_cap: assert property (@(posedge clock) disable iff (reset)
      wr && req_offset == OFF_QUEUE_NUM && req_write_data == 32'd0
      |=> $stable(qlen_ff[0])) else $error("zero queue size taken");
   a_nq_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.capture && !nv_in |-> nq_in == 16'd0) else $error("stray notify queue");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      wr && req_offset == OFF_STATUS && req_write_data == 32'd0
      |=> status_ff == 8'd0 && int_ff == 2'd0) else $error("device reset incomplete");
`endif

endmodule

>>> hw/rtl/virtio_mmio_transport_registers_core.sv
// channel | dir | ports
// req     | in  | req_valid req_ready req_kind req_offset req_write_data
// rsp     | out | rsp_valid rsp_ready rsp_read_data rsp_notify_* rsp_interrupt_pending
// csr     | in  | csr_write_enable csr_index csr_write_data
// one beat per cycle unless rsp stalls; a result appears the cycle after its beat,
// set by the single result register; a new beat is taken as the held result leaves.
// reset is synchronous and clears all transport state; a stalled rsp holds.
// depends on vmmio_pkg, vmmio_ctrl, vmmio_datapath
`timescale 1ns / 1ps

module virtio_mmio_transport_registers_core
   import vmmio_pkg::*;
#(
   parameter int NUM_QUEUES     = NUM_QUEUES_DEF,
   parameter int MAX_QUEUE_SIZE = MAX_QUEUE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_notify_valid,
   output logic [15:0] rsp_notify_queue,
   output logic        rsp_interrupt_pending,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   cmd_type cmd;

   vmmio_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   vmmio_datapath #(
      .NUM_QUEUES     (NUM_QUEUES),
      .MAX_QUEUE_SIZE (MAX_QUEUE_SIZE)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_kind              (req_kind),
      .req_offset            (req_offset),
      .req_write_data        (req_write_data),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_read_data         (rsp_read_data),
      .rsp_notify_valid      (rsp_notify_valid),
      .rsp_notify_queue      (rsp_notify_queue),
      .rsp_interrupt_pending (rsp_interrupt_pending)
   );

endmodule

>>> tb/sv/vmmio_scoreboard.sv
// vmmio_scoreboard: watches the req and rsp channels of the register core,
// predicts every response and compares it field by field; depends on vmmio_pkg
`timescale 1ns / 1ps

module vmmio_scoreboard
   import vmmio_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_offset,
   input  logic [31:0] req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_notify_valid,
   input  logic [15:0] rsp_notify_queue,
   input  logic        rsp_interrupt_pending,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_seen
);

   localparam int NQ = NUM_QUEUES_DEF;

   typedef struct packed {
      logic [31:0] read_data;
      logic        notify_valid;
      logic [15:0] notify_queue;
      logic        interrupt_pending;
   } rsp_beat_type;

   rsp_beat_type expected_rsps[$];

   logic [7:0]  dev_id;
   logic [63:0] dev_features;
   logic [8:0]  size_limit;
   logic [7:0]  status_q;
   logic        dev_page_q, drv_page_q;
   logic [63:0] drv_features;
   logic [15:0] sel_q;
   logic [15:0] qnum_q [NQ];
   logic        qrdy_q [NQ];
   logic [63:0] desc_q [NQ], avail_q [NQ], used_q [NQ];
   logic [1:0]  irq_q;

   task automatic clear_transport();
      status_q = '0; dev_page_q = 0; drv_page_q = 0; drv_features = '0; sel_q = '0;
      irq_q = '0;
      for (int i = 0; i < NQ; i++) begin
         qnum_q[i] = '0; qrdy_q[i] = 0; desc_q[i] = '0; avail_q[i] = '0; used_q[i] = '0;
      end
   endtask

   function automatic logic [31:0] size_cap();
      return (size_limit > MAX_QUEUE_SIZE_DEF) ? 32'(MAX_QUEUE_SIZE_DEF) : 32'(size_limit);
   endfunction

   function automatic logic [63:0] put_half(logic [63:0] w, logic hi, logic [31:0] v);
      if (hi) return {v, w[31:0]};
      return {w[63:32], v};
   endfunction

   task automatic predict_access(input logic [1:0] kind, input logic [7:0] off,
                                 input logic [31:0] v, output rsp_beat_type r);
      logic        q_ok;
      int          q;
      logic [7:0]  s;
      q_ok = sel_q < NQ;
      q = q_ok ? int'(sel_q) : 0;
      r = '0;
      if (kind == KIND_READ && off[1:0] == 2'b00) begin
         case (off)
            OFF_MAGIC:      r.read_data = MAGIC_VALUE;
            OFF_VERSION:    r.read_data = VERSION_VALUE;
            OFF_DEVICE_ID:  r.read_data = {24'd0, dev_id};
            OFF_DEV_FEAT:   r.read_data = dev_page_q ? dev_features[63:32] : dev_features[31:0];
            OFF_QUEUE_MAX:  r.read_data = q_ok ? size_cap() : 32'd0;
            OFF_QUEUE_RDY:  r.read_data = q_ok ? {31'd0, qrdy_q[q]} : 32'd0;
            OFF_INT_STATUS: r.read_data = {30'd0, irq_q};
            OFF_STATUS:     r.read_data = {24'd0, status_q};
            default:        r.read_data = '0;
         endcase
      end else if (kind == KIND_WRITE && off[1:0] == 2'b00) begin
         case (off)
            OFF_NOTIFY: begin
               r.notify_valid = 1;
               r.notify_queue = v[15:0];
            end
            OFF_DEV_PAGE:  dev_page_q = v[0];
            OFF_DRV_FEAT:  drv_features = put_half(drv_features, drv_page_q, v);
            OFF_DRV_PAGE:  drv_page_q = v[0];
            OFF_QUEUE_SEL: sel_q = v[15:0];
            OFF_QUEUE_NUM: if (q_ok && v != 0 && v <= size_cap()) qnum_q[q] = v[15:0];
            OFF_QUEUE_RDY: if (q_ok) qrdy_q[q] = v[0];
            OFF_INT_ACK:   irq_q = irq_q & ~v[1:0];
            OFF_STATUS: begin
               if (v == 0) begin
                  clear_transport();
               end else begin
                  s = v[7:0];
                  // features_ok sticks only for a valid version-1 subset
                  if ((s & ST_FEATURES_OK) != 0 &&
                      !((drv_features & ~dev_features) == 0 && drv_features[VERSION_1_BIT]))
                     s = s & ~ST_FEATURES_OK;
                  status_q = s;
               end
            end
            OFF_DESC_LO:  if (q_ok) desc_q[q]  = put_half(desc_q[q], 0, v);
            OFF_DESC_HI:  if (q_ok) desc_q[q]  = put_half(desc_q[q], 1, v);
            OFF_AVAIL_LO: if (q_ok) avail_q[q] = put_half(avail_q[q], 0, v);
            OFF_AVAIL_HI: if (q_ok) avail_q[q] = put_half(avail_q[q], 1, v);
            OFF_USED_LO:  if (q_ok) used_q[q]  = put_half(used_q[q], 0, v);
            OFF_USED_HI:  if (q_ok) used_q[q]  = put_half(used_q[q], 1, v);
            default: ;
         endcase
      end else if (kind == KIND_RAISE) begin
         irq_q = irq_q | v[1:0];
      end
      r.interrupt_pending = irq_q != 0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on beat %0d: %s got %h expected %h", rsp_seen, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_seen = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_beat_type r, e;
      if (reset) begin
         dev_id = '0; dev_features = 64'h1_0000_0000; size_limit = 9'd256;
         clear_transport();
         expected_rsps.delete();
      end else begin
         // rsp first: a req beat never produces a rsp in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", rsp_read_data, 32'd0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_read_data !== e.read_data)
                  report_mismatch("read_data", rsp_read_data, e.read_data);
               if (rsp_notify_valid !== e.notify_valid)
                  report_mismatch("notify_valid", 32'(rsp_notify_valid),
                                  32'(e.notify_valid));
               if (rsp_notify_queue !== e.notify_queue)
                  report_mismatch("notify_queue", 32'(rsp_notify_queue),
                                  32'(e.notify_queue));
               if (rsp_interrupt_pending !== e.interrupt_pending)
                  report_mismatch("interrupt_pending", 32'(rsp_interrupt_pending),
                                  32'(e.interrupt_pending));
            end
            rsp_seen++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEVICE_KIND: dev_id = csr_write_data[7:0];
               CSR_OFFERED:     dev_features = csr_write_data;
               CSR_SIZE_LIMIT:  size_limit = csr_write_data[8:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_access(req_kind, req_offset, req_write_data, r);
            expected_rsps.push_back(r);
         end
      end
      pending_count = expected_rsps.size();
   end

endmodule

>>> tb/sv/tb_virtio_mmio_transport_registers_core.sv
// tb_virtio_mmio_transport_registers_core: clock, reset, csr and req stimulus
// with random idling; depends on vmmio_pkg, the core and vmmio_scoreboard
`timescale 1ns / 1ps

module tb_virtio_mmio_transport_registers_core;
   import vmmio_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_offset;
   logic [31:0] req_write_data;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_notify_valid;
   logic [15:0] rsp_notify_queue;
   logic        rsp_interrupt_pending;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;
   int          fail_count, pending_count, rsp_seen;
   int          send_idle_pct, recv_stall_pct;
   logic        hold_off;
   int          quiet_cycles;

   virtio_mmio_transport_registers_core u_dut (.*);

   vmmio_scoreboard u_scoreboard (.*);

   localparam logic [7:0] REG_OFFSETS [21] = '{
      OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_DEV_FEAT, OFF_DEV_PAGE, OFF_DRV_FEAT,
      OFF_DRV_PAGE, OFF_QUEUE_SEL, OFF_QUEUE_MAX, OFF_QUEUE_NUM, OFF_QUEUE_RDY, OFF_NOTIFY,
      OFF_INT_STATUS, OFF_INT_ACK, OFF_STATUS, OFF_DESC_LO, OFF_DESC_HI, OFF_AVAIL_LO,
      OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI};

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver side: random stalls, or a long hold-off
   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(posedge clock);
      wait (quiet_cycles >= IDLE_LIMIT);
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // called at a falling edge; valid stays high after a beat until the next
   // call either replaces the payload or idles
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] off,
                            input logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_offset <= off;
      req_write_data <= v;
      // ready is stable from just after the falling edge to the rising edge
      #1;
      while (!req_ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic release_req();
      req_valid <= 0;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] v);
      release_req();
      // only while nothing is in flight
      wait (pending_count == 0);
      repeat (3) @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(3);
         3: return $urandom_range(300);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_beat();
      logic [1:0]  kind;
      logic [7:0]  off;
      kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      off = ($urandom_range(9) == 0) ? 8'($urandom) : REG_OFFSETS[$urandom_range(20)];
      // keep status resets rare so that setup state builds up
      if (kind == KIND_WRITE && off == OFF_STATUS && $urandom_range(3) != 0)
         send_beat(kind, off, 32'($urandom_range(255, 1)));
      else if (kind == KIND_WRITE && off == OFF_QUEUE_SEL && $urandom_range(3) != 0)
         send_beat(kind, off, 32'($urandom_range(2)));
      else
         send_beat(kind, off, rand_value());
   endtask

   // driver bring-up: features, queues, status
   task automatic bring_up();
      send_beat(KIND_WRITE, OFF_STATUS, 32'd0);
      send_beat(KIND_WRITE, OFF_STATUS, 32'd3);
      send_beat(KIND_WRITE, OFF_DEV_PAGE, 32'($urandom));
      send_beat(KIND_READ, OFF_DEV_FEAT, 0);
      send_beat(KIND_WRITE, OFF_DRV_PAGE, 32'd1);
      send_beat(KIND_WRITE, OFF_DRV_FEAT, $urandom_range(1) ? 32'd1 : $urandom);
      send_beat(KIND_WRITE, OFF_DRV_PAGE, 32'd0);
      send_beat(KIND_WRITE, OFF_DRV_FEAT, $urandom_range(1) ? 32'd0 : $urandom);
      send_beat(KIND_WRITE, OFF_STATUS, 32'h0B);
      send_beat(KIND_READ, OFF_STATUS, 0);
      for (int i = 0; i < 2; i++) begin
         send_beat(KIND_WRITE, OFF_QUEUE_SEL, 32'(i));
         send_beat(KIND_READ, OFF_QUEUE_MAX, 0);
         send_beat(KIND_WRITE, OFF_QUEUE_NUM, 32'($urandom_range(300)));
         send_beat(KIND_WRITE, REG_OFFSETS[15 + $urandom_range(5)], $urandom);
         send_beat(KIND_WRITE, OFF_QUEUE_RDY, $urandom);
         send_beat(KIND_READ, OFF_QUEUE_RDY, 0);
      end
      send_beat(KIND_WRITE, OFF_STATUS, 32'h0F);
   endtask

   task automatic random_phase(input int beats);
      int n;
      n = 0;
      while (n < beats) begin
         if ($urandom_range(3) == 0) begin
            bring_up();
            n += 23;
         end else begin
            random_beat();
            n++;
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_kind = '0; req_offset = '0; req_write_data = '0;
      rsp_ready = 0; csr_write_enable = 0; csr_index = '0; csr_write_data = '0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: identity, 13 of the 21 offsets, corner cases
      send_beat(KIND_READ, OFF_MAGIC, 0);
      send_beat(KIND_READ, OFF_VERSION, 0);
      send_beat(KIND_READ, OFF_DEVICE_ID, 0);
      send_beat(KIND_READ, OFF_DEV_FEAT, 0);
      send_beat(KIND_WRITE, OFF_DEV_PAGE, 32'hFFFF_FFFF);
      send_beat(KIND_READ, OFF_DEV_FEAT, 0);
      send_beat(KIND_READ, 8'h01, 0);
      send_beat(KIND_WRITE, OFF_MAGIC, 32'hFFFF_FFFF);
      send_beat(KIND_READ, OFF_QUEUE_NUM, 0);
      send_beat(KIND_WRITE, OFF_QUEUE_NUM, 32'd256);
      send_beat(KIND_WRITE, OFF_QUEUE_NUM, 32'd257);
      send_beat(KIND_WRITE, OFF_QUEUE_NUM, 32'd0);
      send_beat(KIND_WRITE, OFF_QUEUE_SEL, 32'hFFFF_FFFF);
      send_beat(KIND_READ, OFF_QUEUE_MAX, 0);
      send_beat(KIND_WRITE, OFF_QUEUE_RDY, 32'd1);
      send_beat(KIND_READ, OFF_QUEUE_RDY, 0);
      send_beat(KIND_WRITE, OFF_NOTIFY, 32'hFFFF_ABCD);
      send_beat(KIND_WRITE, 8'h52, 32'd1);
      send_beat(KIND_RAISE, 8'hFF, 32'hFFFF_FFFF);
      send_beat(KIND_READ, OFF_INT_STATUS, 0);
      send_beat(KIND_WRITE, OFF_INT_ACK, 32'd1);
      send_beat(2'd3, OFF_STATUS, 32'hFFFF_FFFF);
      send_beat(KIND_WRITE, OFF_STATUS, 32'hFF);
      send_beat(KIND_READ, OFF_STATUS, 0);
      send_beat(KIND_WRITE, OFF_STATUS, 32'd0);

      write_csr(CSR_DEVICE_KIND, 64'hFF);
      write_csr(CSR_OFFERED, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_SIZE_LIMIT, 64'd0);
      random_phase(150);

      send_idle_pct = 74;
      write_csr(CSR_SIZE_LIMIT, 64'h1FF);
      write_csr(CSR_OFFERED, 64'd0);
      random_phase(150);

      send_idle_pct = 0; recv_stall_pct = 74;
      write_csr(CSR_DEVICE_KIND, 64'($urandom_range(255)));
      write_csr(CSR_OFFERED, {$urandom, $urandom} | 64'h1_0000_0000);
      write_csr(CSR_SIZE_LIMIT, 64'($urandom_range(256, 1)));
      random_phase(200);

      send_idle_pct = 30; recv_stall_pct = 30;
      write_csr(CSR_OFFERED, {$urandom, $urandom});
      write_csr(CSR_SIZE_LIMIT, 64'd1);
      random_phase(200);

      // long receiver hold-off while beats keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      write_csr(CSR_SIZE_LIMIT, 64'd256);
      hold_off = 1;
      fork
         begin
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         random_phase(30);
      join
      random_phase(200);

      release_req();
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d responses over five idling phases and csr extremes", rsp_seen);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/vmmio_pkg.sv
hw/rtl/vmmio_ctrl.sv
hw/rtl/vmmio_datapath.sv
hw/rtl/virtio_mmio_transport_registers_core.sv
tb/sv/vmmio_scoreboard.sv
tb/sv/tb_virtio_mmio_transport_registers_core.sv
